FILE: rtl/pa_pkg.sv
// Shared types and constants for the primitive assembly block.
package pa_pkg;

   // Widths of the stream fields and the depth of the result queue
   localparam int FIELD_WIDTH        = 16;
   localparam int INDEX_WIDTH_DEFAULT = 16;
   localparam int TYPE_WIDTH         = 4;
   localparam int REQ_DATA_WIDTH     = 24;
   localparam int RSP_DATA_WIDTH     = 56;
   localparam int RSP_DEPTH          = 4;

   // Primitive type register codes
   localparam logic [TYPE_WIDTH-1:0] PT_POINTS      = 4'd0;
   localparam logic [TYPE_WIDTH-1:0] PT_LINES       = 4'd1;
   localparam logic [TYPE_WIDTH-1:0] PT_LINE_LOOP   = 4'd2;
   localparam logic [TYPE_WIDTH-1:0] PT_LINE_STRIP  = 4'd3;
   localparam logic [TYPE_WIDTH-1:0] PT_TRIS        = 4'd4;
   localparam logic [TYPE_WIDTH-1:0] PT_TRI_STRIP   = 4'd5;
   localparam logic [TYPE_WIDTH-1:0] PT_TRI_FAN     = 4'd6;
   localparam logic [TYPE_WIDTH-1:0] PT_QUADS       = 4'd7;
   localparam logic [TYPE_WIDTH-1:0] PT_QUAD_STRIP  = 4'd8;
   localparam logic [TYPE_WIDTH-1:0] PT_POLYGON     = 4'd9;

   // Reduced primitive classes
   localparam logic [1:0] CLS_POINT    = 2'd0;
   localparam logic [1:0] CLS_LINE     = 2'd1;
   localparam logic [1:0] CLS_TRIANGLE = 2'd2;

   // Edge masks
   localparam logic [2:0] EDGE_SINGLE    = 3'b001;
   localparam logic [2:0] EDGE_ALL       = 3'b111;
   localparam logic [2:0] EDGE_SKIP_MID  = 3'b101;
   localparam logic [2:0] EDGE_SKIP_LAST = 3'b011;
   localparam logic [2:0] POLY_MASK_INIT = 3'b101;
   localparam logic [2:0] POLY_CLOSE     = 3'b010;

   typedef logic [FIELD_WIDTH-1:0] pa_idx_type;

   typedef struct packed {
      logic [1:0] prim_class;
      pa_idx_type first_vertex;
      pa_idx_type second_vertex;
      pa_idx_type third_vertex;
      logic [2:0] edge_mask;
      logic       stipple_restart;
      logic       last_of_run;
   } pa_result_type;

   typedef struct packed {
      logic [1:0]    count;
      pa_result_type res0;
      pa_result_type res1;
   } pa_push_type;

endpackage

FILE: rtl/pa_assemble.sv
// Vertex input register, draw state and primitive assembly logic.
module pa_assemble #(
   parameter int INDEX_WIDTH = pa_pkg::INDEX_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [pa_pkg::TYPE_WIDTH-1:0]  csr_wr_data,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [pa_pkg::FIELD_WIDTH-1:0] req_vertex_index,
   input  logic                           req_vertex_edge_flag,
   input  logic                           req_last_vertex,
   input  logic                           room,
   output pa_pkg::pa_push_type            push
);
   import pa_pkg::*;

   localparam int KeepWidth = (INDEX_WIDTH < FIELD_WIDTH) ? INDEX_WIDTH : FIELD_WIDTH;
   localparam int VertWidth = KeepWidth + 1;

   typedef logic [VertWidth-1:0] vert_type;

   logic                  in_valid_ff, in_valid_in;
   logic [KeepWidth-1:0]  index_ff, index_in;
   logic                  flag_ff, flag_in;
   logic                  last_ff, last_in;

   logic [TYPE_WIDTH-1:0] prim_type_ff, prim_type_in;
   vert_type              start_ff, start_in;
   vert_type              hist0_ff, hist0_in;
   vert_type              hist1_ff, hist1_in;
   vert_type              hist2_ff, hist2_in;
   logic [3:0]            pos_ff, pos_in;
   logic [1:0]            seen_ff, seen_in;
   logic [2:0]            poly_ff, poly_in;

   logic                  accept;
   logic                  fire;
   vert_type              cur;
   vert_type              first;
   logic [1:0]            res_count;
   logic [2:0]            poly_edges;
   logic [2:0]            poly_after;
   pa_result_type         res0;
   pa_result_type         res1;

   function automatic pa_result_type make_res(input logic [1:0] cls, input vert_type a,
                                              input vert_type b, input vert_type c,
                                              input logic [2:0] mask, input logic rs);
      pa_result_type r;
      r.prim_class      = cls;
      r.first_vertex    = pa_idx_type'(a[KeepWidth-1:0]);
      r.second_vertex   = pa_idx_type'(b[KeepWidth-1:0]);
      r.third_vertex    = pa_idx_type'(c[KeepWidth-1:0]);
      r.edge_mask       = mask;
      r.stipple_restart = rs;
      r.last_of_run     = 1'b0;
      return r;
   endfunction

   function automatic logic [2:0] ef3(input vert_type a, input vert_type b, input vert_type c);
      return {c[KeepWidth], b[KeepWidth], a[KeepWidth]};
   endfunction

   assign req_tready = !in_valid_ff || room;
   assign accept     = req_tvalid && req_tready;
   assign fire       = in_valid_ff && room;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      index_in    = index_ff;
      flag_in     = flag_ff;
      last_in     = last_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         index_in    = req_vertex_index[KeepWidth-1:0];
         flag_in     = req_vertex_edge_flag;
         last_in     = req_last_vertex;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   assign cur   = {flag_ff, index_ff};
   assign first = (seen_ff == 2'd0) ? cur : start_ff;

   // Assemble the primitive(s) closed by the current vertex
   always_comb begin
      res_count  = 2'd0;
      res0       = '0;
      res1       = '0;
      poly_edges = '0;
      poly_after = poly_ff;
      case (prim_type_ff)
         PT_POINTS: begin
            res0      = make_res(CLS_POINT, cur, '0, '0, EDGE_SINGLE, 1'b0);
            res_count = 2'd1;
         end
         PT_LINES: begin
            if (pos_ff[0]) begin
               res0      = make_res(CLS_LINE, hist0_ff, cur, '0, EDGE_SINGLE, 1'b1);
               res_count = 2'd1;
            end
         end
         PT_LINE_LOOP, PT_LINE_STRIP: begin
            if (seen_ff != 2'd0) begin
               res0 = make_res(CLS_LINE, hist0_ff, cur, '0, EDGE_SINGLE,
                               seen_ff == 2'd1);
               res_count = 2'd1;
               // close the loop back to the first vertex
               if (prim_type_ff == PT_LINE_LOOP && last_ff) begin
                  res1      = make_res(CLS_LINE, cur, first, '0, EDGE_SINGLE, 1'b0);
                  res_count = 2'd2;
               end
            end
         end
         PT_TRIS: begin
            if (pos_ff == 4'd2 || pos_ff == 4'd5 || pos_ff == 4'd8 || pos_ff == 4'd11) begin
               res0 = make_res(CLS_TRIANGLE, hist1_ff, hist0_ff, cur,
                               ef3(hist1_ff, hist0_ff, cur), 1'b1);
               res_count = 2'd1;
            end
         end
         PT_TRI_STRIP: begin
            if (seen_ff[1]) begin
               if (pos_ff[0]) begin
                  res0 = make_res(CLS_TRIANGLE, hist0_ff, hist1_ff, cur, EDGE_ALL, 1'b1);
               end else begin
                  res0 = make_res(CLS_TRIANGLE, hist1_ff, hist0_ff, cur, EDGE_ALL, 1'b1);
               end
               res_count = 2'd1;
            end
         end
         PT_TRI_FAN: begin
            if (seen_ff[1]) begin
               res0      = make_res(CLS_TRIANGLE, first, hist0_ff, cur, EDGE_ALL, 1'b1);
               res_count = 2'd1;
            end
         end
         PT_QUADS: begin
            if (pos_ff[1:0] == 2'b11) begin
               res0 = make_res(CLS_TRIANGLE, hist2_ff, hist1_ff, cur,
                               ef3(hist2_ff, hist1_ff, cur) & EDGE_SKIP_MID, 1'b1);
               res1 = make_res(CLS_TRIANGLE, hist1_ff, hist0_ff, cur,
                               ef3(hist1_ff, hist0_ff, cur) & EDGE_SKIP_LAST, 1'b0);
               res_count = 2'd2;
            end
         end
         PT_QUAD_STRIP: begin
            if (seen_ff == 2'd3 && pos_ff[0]) begin
               res0 = make_res(CLS_TRIANGLE, hist0_ff, hist2_ff, cur,
                               ef3(hist0_ff, hist2_ff, cur) & EDGE_SKIP_MID, 1'b1);
               res1 = make_res(CLS_TRIANGLE, hist2_ff, hist1_ff, cur,
                               ef3(hist2_ff, hist1_ff, cur) & EDGE_SKIP_LAST, 1'b0);
               res_count = 2'd2;
            end
         end
         PT_POLYGON: begin
            if (seen_ff[1]) begin
               poly_edges = poly_ff | (last_ff ? POLY_CLOSE : 3'b000);
               res0 = make_res(CLS_TRIANGLE, hist0_ff, cur, first,
                               poly_edges & ef3(hist0_ff, cur, first), seen_ff == 2'd2);
               res_count  = 2'd1;
               poly_after = poly_ff & EDGE_SKIP_LAST;
            end
         end
         default: begin
            res_count = 2'd0;
         end
      endcase
      if (res_count == 2'd1) begin
         res0.last_of_run = 1'b1;
      end
      if (res_count == 2'd2) begin
         res1.last_of_run = 1'b1;
      end
   end

   assign push.count = fire ? res_count : 2'd0;
   assign push.res0  = res0;
   assign push.res1  = res1;

   // Draw state: restart on a register write or after the final vertex
   always_comb begin
      prim_type_in = prim_type_ff;
      start_in     = start_ff;
      hist0_in     = hist0_ff;
      hist1_in     = hist1_ff;
      hist2_in     = hist2_ff;
      pos_in       = pos_ff;
      seen_in      = seen_ff;
      poly_in      = poly_ff;
      if (csr_wr_en || (fire && last_ff)) begin
         if (csr_wr_en) begin
            prim_type_in = csr_wr_data;
         end
         start_in = '0;
         hist0_in = '0;
         hist1_in = '0;
         hist2_in = '0;
         pos_in   = '0;
         seen_in  = '0;
         poly_in  = POLY_MASK_INIT;
      end else if (fire) begin
         start_in = first;
         hist2_in = hist1_ff;
         hist1_in = hist0_ff;
         hist0_in = cur;
         pos_in   = (pos_ff >= 4'd11) ? 4'd0 : pos_ff + 4'd1;
         seen_in  = (seen_ff == 2'd3) ? 2'd3 : seen_ff + 2'd1;
         poly_in  = poly_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         prim_type_ff <= PT_POINTS;
         start_ff     <= '0;
         hist0_ff     <= '0;
         hist1_ff     <= '0;
         hist2_ff     <= '0;
         pos_ff       <= '0;
         seen_ff      <= '0;
         poly_ff      <= POLY_MASK_INIT;
      end else begin
         in_valid_ff  <= in_valid_in;
         prim_type_ff <= prim_type_in;
         start_ff     <= start_in;
         hist0_ff     <= hist0_in;
         hist1_ff     <= hist1_in;
         hist2_ff     <= hist2_in;
         pos_ff       <= pos_in;
         seen_ff      <= seen_in;
         poly_ff      <= poly_in;
      end
   end

   always_ff @(posedge clock) begin
      index_ff <= index_in;
      flag_ff  <= flag_in;
      last_ff  <= last_in;
   end

endmodule

FILE: rtl/pa_rsp_fifo.sv
// Small result queue that takes up to two results per cycle and drains one.
module pa_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  pa_pkg::pa_push_type   push,
   output logic                  room,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output pa_pkg::pa_result_type rsp_entry
);
   import pa_pkg::*;

   localparam int PtrWidth   = $clog2(RSP_DEPTH);
   localparam int CountWidth = $clog2(RSP_DEPTH + 1);

   pa_result_type         entries_ff [RSP_DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [PtrWidth-1:0]   wr_slot2;
   logic                  pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_entry  = entries_ff[rd_ptr_ff];
   assign room       = (count_ff <= CountWidth'(RSP_DEPTH - 2));
   assign wr_slot2   = wr_ptr_ff + PtrWidth'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrWidth'(push.count);
      rd_ptr_in = rd_ptr_ff + PtrWidth'(pop);
      count_in  = count_ff + CountWidth'(push.count) - CountWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_slot2] <= push.res1;
      end
   end

endmodule

FILE: rtl/primitive_assembly.sv
// Primitive assembly top level: vertex stream in, point/line/triangle stream out.
// Flow: an accepted vertex sits in the input register; its results are written to
//   the result queue once it has room, and show on rsp_ from then on.
// Throughput: one vertex per cycle while the queue has room; quads, quad strips and
//   a closing loop line give two results; the 4-entry queue drains one per cycle.
// Reset: synchronous, active high; primitive type returns to points, draw state clears.
module primitive_assembly #(
   parameter int INDEX_WIDTH = pa_pkg::INDEX_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration: primitive_type
   input  logic                              csr_wr_en,
   input  logic [pa_pkg::TYPE_WIDTH-1:0]     csr_wr_data,
   // vertex stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata from bit 0: vertex_index[15:0], vertex_edge_flag, zero fill
   input  logic [pa_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic                              req_tlast,       // last_vertex
   // primitive stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata from bit 0: prim_class[1:0], first_vertex[15:0], second_vertex[15:0],
   //   third_vertex[15:0], edge_mask[2:0], stipple_restart, zero fill
   output logic [pa_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                              rsp_tlast        // last_of_run
);
   import pa_pkg::*;

   pa_push_type   push;
   pa_result_type rsp_entry;
   logic          room;

   // Hold the vertex, assemble primitives against the draw history, advance the state.
   pa_assemble #(
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_assemble (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_tvalid           (req_tvalid),
      .req_tready           (req_tready),
      .req_vertex_index     (req_tdata[FIELD_WIDTH-1:0]),
      .req_vertex_edge_flag (req_tdata[FIELD_WIDTH]),
      .req_last_vertex      (req_tlast),
      .room                 (room),
      .push                 (push)
   );

   // Queue the results; stall the vertex stage when fewer than two slots are free.
   pa_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_entry  (rsp_entry)
   );

   // Pack the result transaction, first field in the low bits.
   assign rsp_tdata = {2'b00,
                       rsp_entry.stipple_restart,
                       rsp_entry.edge_mask,
                       rsp_entry.third_vertex,
                       rsp_entry.second_vertex,
                       rsp_entry.first_vertex,
                       rsp_entry.prim_class};
   assign rsp_tlast = rsp_entry.last_of_run;

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the primitive assembly block: vertex stream in, primitives out.
`timescale 1ns / 100ps

module tb_top;
   import pa_pkg::*;

   // Primitive type codes the block accepts but never assembles
   localparam logic [TYPE_WIDTH-1:0] PT_UNUSED_MIN = 4'd10;
   localparam logic [TYPE_WIDTH-1:0] PT_UNUSED_MAX = 4'd15;
   localparam logic [3:0]            POS_WRAP      = 4'd11;
   localparam logic [2:0]            NO_CLOSE      = 3'b000;
   localparam int                    SETTLE_CYCLES = 4;
   localparam int                    DRAIN_CYCLES  = 8;
   localparam int                    STALL_CYCLES  = 80;
   localparam int                    PRINT_CAP     = 40;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [TYPE_WIDTH-1:0]     csr_wr_data = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic                      req_tlast = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tlast;

   // Draw state of the bench's own assembly model
   logic [TYPE_WIDTH-1:0] draw_type;
   logic [16:0]           draw_start;
   logic [16:0]           draw_hist [3];
   logic [3:0]            draw_pos;
   logic [1:0]            draw_seen;
   logic [2:0]            poly_mask;

   // Primitives predicted but not yet seen on the output, oldest first
   pa_result_type pending_prims[$];

   int error_count     = 0;
   int sender_idle_pct = 0;
   int recv_idle_pct   = 0;
   int stall_left      = 0;
   bit stall_request   = 1'b0;
   int dir_k           = 0;

   primitive_assembly u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   // Clear the draw, as at the end of a draw or on a type write.
   function automatic void restart_draw();
      draw_start   = '0;
      draw_hist[0] = '0;
      draw_hist[1] = '0;
      draw_hist[2] = '0;
      draw_pos     = '0;
      draw_seen    = '0;
      poly_mask    = POLY_MASK_INIT;
   endfunction

   // Gather the edge flags of three stored vertices, first vertex in bit 0.
   function automatic logic [2:0] edge_flags(logic [16:0] a, logic [16:0] b, logic [16:0] c);
      return {c[16], b[16], a[16]};
   endfunction

   function automatic void push_prim(logic [1:0] cls, logic [16:0] a, logic [16:0] b,
                                     logic [16:0] c, logic [2:0] mask, logic rs);
      pa_result_type prim;
      prim.prim_class      = cls;
      prim.first_vertex    = a[15:0];
      prim.second_vertex   = (cls != CLS_POINT) ? b[15:0] : '0;
      prim.third_vertex    = (cls == CLS_TRIANGLE) ? c[15:0] : '0;
      prim.edge_mask       = mask;
      prim.stipple_restart = rs;
      prim.last_of_run     = 1'b0;
      pending_prims.push_back(prim);
   endfunction

   // Assemble the primitives one accepted vertex completes, then advance the draw.
   function automatic void assemble_vertex(logic [15:0] idx, logic ef, logic last_v);
      logic [16:0]   cur;
      logic [16:0]   first_v;
      logic [16:0]   h0;
      logic [16:0]   h1;
      logic [16:0]   h2;
      logic [2:0]    poly_m;
      int unsigned   n_before;
      pa_result_type tail;
      cur      = {ef, idx};
      h0       = draw_hist[0];
      h1       = draw_hist[1];
      h2       = draw_hist[2];
      first_v  = (draw_seen == 2'd0) ? cur : draw_start;
      n_before = pending_prims.size();
      case (draw_type)
         PT_POINTS:
            push_prim(CLS_POINT, cur, '0, '0, EDGE_SINGLE, 1'b0);
         PT_LINES:
            if (draw_pos[0]) push_prim(CLS_LINE, h0, cur, '0, EDGE_SINGLE, 1'b1);
         PT_LINE_LOOP, PT_LINE_STRIP:
            if (draw_seen >= 2'd1) begin
               push_prim(CLS_LINE, h0, cur, '0, EDGE_SINGLE, draw_seen == 2'd1);
               // closing line back to the first vertex of the loop
               if (draw_type == PT_LINE_LOOP && last_v)
                  push_prim(CLS_LINE, cur, first_v, '0, EDGE_SINGLE, 1'b0);
            end
         PT_TRIS:
            if (draw_pos % 4'd3 == 4'd2)
               push_prim(CLS_TRIANGLE, h1, h0, cur, edge_flags(h1, h0, cur), 1'b1);
         PT_TRI_STRIP:
            if (draw_seen >= 2'd2) begin
               // odd triangles swap the first two vertices to keep the winding
               if (draw_pos[0]) push_prim(CLS_TRIANGLE, h0, h1, cur, EDGE_ALL, 1'b1);
               else             push_prim(CLS_TRIANGLE, h1, h0, cur, EDGE_ALL, 1'b1);
            end
         PT_TRI_FAN:
            if (draw_seen >= 2'd2) push_prim(CLS_TRIANGLE, first_v, h0, cur, EDGE_ALL, 1'b1);
         PT_QUADS:
            if (draw_pos[1:0] == 2'd3) begin
               push_prim(CLS_TRIANGLE, h2, h1, cur,
                         edge_flags(h2, h1, cur) & EDGE_SKIP_MID, 1'b1);
               push_prim(CLS_TRIANGLE, h1, h0, cur,
                         edge_flags(h1, h0, cur) & EDGE_SKIP_LAST, 1'b0);
            end
         PT_QUAD_STRIP:
            if (draw_seen == 2'd3 && draw_pos[0]) begin
               push_prim(CLS_TRIANGLE, h0, h2, cur,
                         edge_flags(h0, h2, cur) & EDGE_SKIP_MID, 1'b1);
               push_prim(CLS_TRIANGLE, h2, h1, cur,
                         edge_flags(h2, h1, cur) & EDGE_SKIP_LAST, 1'b0);
            end
         PT_POLYGON:
            if (draw_seen >= 2'd2) begin
               poly_m = poly_mask | (last_v ? POLY_CLOSE : NO_CLOSE);
               push_prim(CLS_TRIANGLE, h0, cur, first_v, poly_m & edge_flags(h0, cur, first_v),
                         draw_seen == 2'd2);
               // the edge from the first vertex to the second is drawn by the first fan triangle only
               poly_mask = poly_mask & EDGE_SKIP_LAST;
            end
         default: ;
      endcase
      // flag the final primitive of this vertex
      if (pending_prims.size() > n_before) begin
         tail = pending_prims.pop_back();
         tail.last_of_run = 1'b1;
         pending_prims.push_back(tail);
      end
      if (last_v) begin
         restart_draw();
      end else begin
         draw_start   = first_v;
         draw_hist[2] = h1;
         draw_hist[1] = h0;
         draw_hist[0] = cur;
         draw_pos     = (draw_pos >= POS_WRAP) ? 4'd0 : draw_pos + 4'd1;
         if (draw_seen != 2'd3) draw_seen = draw_seen + 2'd1;
      end
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < PRINT_CAP)
         $display("tb_top: %s: got 0x%0h, want 0x%0h", what, got, want);
      error_count++;
   endtask

   // Offer one vertex, idling first at the sender's rate; return on the accepting edge.
   task automatic send_vertex(input logic [15:0] idx, input logic ef, input logic last_v);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_WIDTH - 17){1'b0}}, ef, idx};
      req_tlast  <= last_v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      assemble_vertex(idx, ef, last_v);
   endtask

   // Drop valid and wait until every predicted primitive is out and the pipe is empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_prims.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the primitive type while the block is idle; the write restarts the draw.
   task automatic write_prim_type(input logic [TYPE_WIDTH-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      draw_type = value;
      restart_draw();
   endtask

   // Mix the extremes into otherwise random indices.
   function automatic logic [15:0] random_index();
      case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Vertex count of a well-formed draw of the given number of primitives.
   function automatic int draw_length(logic [TYPE_WIDTH-1:0] t, int prims);
      case (t)
         PT_POINTS:                 return prims;
         PT_LINES:                  return 2 * prims;
         PT_LINE_LOOP, PT_LINE_STRIP: return prims + 1;
         PT_TRIS:                   return 3 * prims;
         PT_TRI_STRIP, PT_TRI_FAN, PT_POLYGON: return prims + 2;
         PT_QUADS:                  return 4 * prims;
         PT_QUAD_STRIP:             return 2 * prims + 2;
         default:                   return prims;
      endcase
   endfunction

   // Directed vertex: alternate the index extremes and vary the edge flag.
   task automatic send_directed(input logic last_v);
      logic [15:0] idx;
      idx = dir_k[0] ? 16'hFFFF - 16'(dir_k) : 16'(dir_k);
      send_vertex(idx, (dir_k % 3) != 1, last_v);
      dir_k++;
   endtask

   // ---------------------------------------------------------------- checker

   // Receiver: random holds at its idle rate, plus one long hold on request.
   always @(posedge clock) begin
      if (stall_request) begin
         stall_left    = STALL_CYCLES;
         stall_request = 1'b0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each output transaction with the oldest predicted primitive.
   always @(posedge clock) begin
      pa_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_prims.size() == 0) begin
            report_mismatch("primitive with none pending", rsp_tdata[31:0], '0);
         end else begin
            want = pending_prims.pop_front();
            if (rsp_tdata[1:0] !== want.prim_class)
               report_mismatch("prim_class", 32'(rsp_tdata[1:0]), 32'(want.prim_class));
            if (rsp_tdata[17:2] !== want.first_vertex)
               report_mismatch("first_vertex", 32'(rsp_tdata[17:2]),
                               32'(want.first_vertex));
            if (rsp_tdata[33:18] !== want.second_vertex)
               report_mismatch("second_vertex", 32'(rsp_tdata[33:18]),
                               32'(want.second_vertex));
            if (rsp_tdata[49:34] !== want.third_vertex)
               report_mismatch("third_vertex", 32'(rsp_tdata[49:34]),
                               32'(want.third_vertex));
            if (rsp_tdata[52:50] !== want.edge_mask)
               report_mismatch("edge_mask", 32'(rsp_tdata[52:50]), 32'(want.edge_mask));
            if (rsp_tdata[53] !== want.stipple_restart)
               report_mismatch("stipple_restart", 32'(rsp_tdata[53]),
                               32'(want.stipple_restart));
            if (rsp_tdata[RSP_DATA_WIDTH-1:54] !== '0)
               report_mismatch("tdata fill", 32'(rsp_tdata[RSP_DATA_WIDTH-1:54]), '0);
            if (rsp_tlast !== want.last_of_run)
               report_mismatch("last_of_run", 32'(rsp_tlast), 32'(want.last_of_run));
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // One short draw of every primitive type, indices at the extremes.
   task automatic test_each_primitive_type();
      int draw_len [10] = '{1, 2, 3, 2, 3, 4, 3, 4, 4, 3};
      int t;
      for (t = PT_POINTS; t <= PT_POLYGON; t++) begin
         write_prim_type(4'(t));
         for (int i = 0; i < draw_len[t - PT_POINTS]; i++)
            send_directed(i == draw_len[t - PT_POINTS] - 1);
      end
   endtask

   // Loop of one vertex, the unused type codes, and a type write in mid draw.
   task automatic test_special_cases();
      write_prim_type(PT_LINE_LOOP);
      send_directed(1'b1);
      write_prim_type(PT_UNUSED_MIN);
      send_directed(1'b1);
      write_prim_type(PT_UNUSED_MAX);
      send_directed(1'b0);
      // leave a fan open, then restart it with a fresh write
      write_prim_type(PT_TRI_FAN);
      send_directed(1'b0);
      send_directed(1'b0);
      write_prim_type(PT_TRI_FAN);
      for (int i = 0; i < 3; i++) send_directed(i == 2);
   endtask

   // Hold the output off for a long stretch while quads keep coming in.
   task automatic test_backpressure();
      sender_idle_pct = 0;
      recv_idle_pct   = 0;
      write_prim_type(PT_QUADS);
      stall_request = 1'b1;
      for (int i = 0; i < 32; i++)
         send_vertex(random_index(), 1'($urandom_range(1)), i == 31);
   endtask

   // Batches of random draws; mostly well-formed, some broken or left open.
   task automatic test_random_draws(input int item_goal);
      int                    sent;
      int                    n_draws;
      int                    len;
      bit                    leave_open;
      logic [TYPE_WIDTH-1:0] t;
      sent = 0;
      while (sent < item_goal) begin
         t = ($urandom_range(9) == 0) ? 4'($urandom_range(PT_UNUSED_MAX, PT_UNUSED_MIN))
                                      : 4'($urandom_range(PT_POLYGON, PT_POINTS));
         write_prim_type(t);
         n_draws = $urandom_range(6, 1);
         for (int d = 0; d < n_draws; d++) begin
            len = ($urandom_range(4) == 0) ? $urandom_range(16, 1)
                                           : draw_length(t, $urandom_range(4, 1));
            // an open draw at the end of a batch is cut off by the next type write
            leave_open = (d == n_draws - 1) && ($urandom_range(11) == 0);
            for (int i = 0; i < len; i++)
               send_vertex(random_index(), 1'($urandom_range(1)),
                           (i == len - 1) && !leave_open);
            if (t <= PT_POLYGON) sent += len;
         end
      end
   endtask

   initial begin
      draw_type = PT_POINTS;
      restart_draw();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_each_primitive_type();
      test_special_cases();
      test_backpressure();

      // sender idles lightly, receiver heavily; then swap; then no idling at all
      sender_idle_pct = 15;
      recv_idle_pct   = 69;
      test_random_draws(650);
      sender_idle_pct = 69;
      recv_idle_pct   = 15;
      test_random_draws(650);
      sender_idle_pct = 0;
      recv_idle_pct   = 0;
      test_random_draws(700);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_prims.size() != 0)
         report_mismatch("primitives never delivered", pending_prims.size(), '0);
      if (error_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   // Stop a hung run.
   initial begin
      #3000000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
